// ===== rtl/ffca_pkg.sv =====
// Shared codes, field widths and the result type of the first-fit allocator.
package ffca_pkg;

    // Operation codes carried on mode
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Status codes carried on status
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    // Fixed field widths of the ports
    localparam int MODE_BITS     = 2;
    localparam int REQ_BITS      = 25;
    localparam int OUT_ADDR_BITS = 24;
    localparam int STATUS_BITS   = 2;
    localparam int POOL_BITS     = 25;

    // Register file
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam logic [0:0] REG_POOL_SIZE = 1'b0;
    localparam logic [POOL_BITS-1:0] POOL_RESET = 25'd16777216;

    typedef struct packed {
        logic [STATUS_BITS-1:0]   status;
        logic [OUT_ADDR_BITS-1:0] granted_address;
    } result_t;

endpackage

// ===== rtl/first_fit_coalescing_allocator.sv =====
// Sequence: allocate scans entries in turn, plus a shift down of later entries
//   when a segment empties; free scans the table entries, plus a shift of
//   entries on insert; clear and unused modes go straight to the result; all plus output stage.
// Throughput: one item at a time, set by the single table read port and the
//   shared adder.
// Reset: one segment spans the pool at once; no clearing pass is needed.
module first_fit_coalescing_allocator #(
    parameter int FREE_SLOTS = 16,
    parameter int ADDR_BITS  = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ffca_pkg::MODE_BITS-1:0]      mode,
    input  logic [ffca_pkg::REQ_BITS-1:0]       request_size,
    input  logic [ffca_pkg::OUT_ADDR_BITS-1:0]  block_address,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ffca_pkg::STATUS_BITS-1:0]    status,
    output logic [ffca_pkg::OUT_ADDR_BITS-1:0]  granted_address,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ffca_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [ffca_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [ffca_pkg::PDATA_BITS-1:0]     prdata,
    output logic                                pready
);
    import ffca_pkg::*;

    localparam int IW = $clog2(FREE_SLOTS);

    logic [POOL_BITS-1:0] pool_size_reg;
    logic                 out_valid_reg;
    result_t              out_data_reg;
    logic                 res_valid, res_ready;
    result_t              result;
    logic                 cfg_write;
    logic [0:0]           reg_index;

    logic                 mem_init, mem_re, mem_we;
    logic [IW-1:0]        mem_raddr, mem_waddr;
    logic [ADDR_BITS-1:0] mem_rstart, mem_wstart;
    logic [ADDR_BITS:0]   mem_rlen, mem_wlen;

    // Register port
    assign pready    = 1'b1;
    assign reg_index = paddr[PADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (reg_index == REG_POOL_SIZE) ? PDATA_BITS'(pool_size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pool_size_reg <= POOL_RESET;
        else if (cfg_write && reg_index == REG_POOL_SIZE)
            pool_size_reg <= pwdata[POOL_BITS-1:0];
    end

    ffca_ctrl #(
        .FREE_SLOTS (FREE_SLOTS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .request_size  (request_size),
        .block_address (block_address),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .result        (result),
        .mem_init      (mem_init),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rstart    (mem_rstart),
        .mem_rlen      (mem_rlen),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wstart    (mem_wstart),
        .mem_wlen      (mem_wlen)
    );

    ffca_seg_mem #(
        .FREE_SLOTS (FREE_SLOTS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .pool_size (pool_size_reg),
        .init      (mem_init),
        .re        (mem_re),
        .raddr     (mem_raddr),
        .rstart    (mem_rstart),
        .rlen      (mem_rlen),
        .we        (mem_we),
        .waddr     (mem_waddr),
        .wstart    (mem_wstart),
        .wlen      (mem_wlen)
    );

    // Output stage: hold a result until its transfer completes
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            out_data_reg <= result;
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_data_reg.status;
    assign granted_address = out_data_reg.granted_address;

endmodule

// ===== rtl/ffca_addsub.sv =====
// Shared adder/subtractor used by the sequencer for its address and length sums.
module ffca_addsub #(
    parameter int WIDTH = 27
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic             sub,
    output logic [WIDTH-1:0] y
);
    // Subtract as add of the complement plus one
    logic [WIDTH-1:0] b_eff;

    assign b_eff = sub ? ~b : b;
    assign y     = a + b_eff + {{(WIDTH-1){1'b0}}, sub};

endmodule

// ===== rtl/ffca_seg_mem.sv =====
// Free-segment table memory with a reset and clear override for entry zero.
module ffca_seg_mem #(
    parameter int FREE_SLOTS = 16,
    parameter int ADDR_BITS  = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ffca_pkg::POOL_BITS-1:0] pool_size,
    input  logic                          init,
    input  logic                          re,
    input  logic [$clog2(FREE_SLOTS)-1:0] raddr,
    output logic [ADDR_BITS-1:0]          rstart,
    output logic [ADDR_BITS:0]            rlen,
    input  logic                          we,
    input  logic [$clog2(FREE_SLOTS)-1:0] waddr,
    input  logic [ADDR_BITS-1:0]          wstart,
    input  logic [ADDR_BITS:0]            wlen
);
    import ffca_pkg::*;

    localparam int IW = $clog2(FREE_SLOTS);
    localparam int LW = ADDR_BITS + 1;

    // Clamp the pool size into one byte up to the full address span
    function automatic logic [LW-1:0] eff_pool(input logic [POOL_BITS-1:0] v);
        logic [LW-1:0] p;
        logic [LW-1:0] span;
        span = {1'b1, {ADDR_BITS{1'b0}}};
        p    = LW'(v);
        if (p == '0)
            p = {{(LW-1){1'b0}}, 1'b1};
        if (p > span)
            p = span;
        return p;
    endfunction

    localparam logic [LW-1:0] RESET_LEN = eff_pool(POOL_RESET);

    logic [ADDR_BITS-1:0] start_mem [FREE_SLOTS];
    logic [LW-1:0]        len_mem   [FREE_SLOTS];
    logic [ADDR_BITS-1:0] rstart_q;
    logic [LW-1:0]        rlen_q;
    logic                 fresh_reg;
    logic                 rd_ovr_reg;
    logic [LW-1:0]        ovr_len_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            start_mem[waddr] <= wstart;
            len_mem[waddr]   <= wlen;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rstart_q <= start_mem[raddr];
            rlen_q   <= len_mem[raddr];
        end
    end

    // Track whether entry zero still holds the whole pool since reset or clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg   <= 1'b1;
            ovr_len_reg <= RESET_LEN;
            rd_ovr_reg  <= 1'b0;
        end
        else
        begin
            if (init)
            begin
                fresh_reg   <= 1'b1;
                ovr_len_reg <= eff_pool(pool_size);
            end
            else if (we && waddr == IW'(0))
                fresh_reg <= 1'b0;
            if (re)
                rd_ovr_reg <= fresh_reg && (raddr == IW'(0));
        end
    end

    // Substitute the whole-pool segment for a fresh entry zero
    assign rstart = rd_ovr_reg ? '0 : rstart_q;
    assign rlen   = rd_ovr_reg ? ovr_len_reg : rlen_q;

endmodule

// ===== rtl/ffca_ctrl.sv =====
// Sequencer that scans, updates and shifts the free-segment table.
module ffca_ctrl #(
    parameter int FREE_SLOTS = 16,
    parameter int ADDR_BITS  = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ffca_pkg::MODE_BITS-1:0]    mode,
    input  logic [ffca_pkg::REQ_BITS-1:0]     request_size,
    input  logic [ffca_pkg::OUT_ADDR_BITS-1:0] block_address,
    output logic                              res_valid,
    input  logic                              res_ready,
    output ffca_pkg::result_t                 result,
    output logic                              mem_init,
    output logic                              mem_re,
    output logic [$clog2(FREE_SLOTS)-1:0]     mem_raddr,
    input  logic [ADDR_BITS-1:0]              mem_rstart,
    input  logic [ADDR_BITS:0]                mem_rlen,
    output logic                              mem_we,
    output logic [$clog2(FREE_SLOTS)-1:0]     mem_waddr,
    output logic [ADDR_BITS-1:0]              mem_wstart,
    output logic [ADDR_BITS:0]                mem_wlen
);
    import ffca_pkg::*;

    localparam int IW = $clog2(FREE_SLOTS);
    localparam int CW = $clog2(FREE_SLOTS + 1);
    localparam int AW = ADDR_BITS;
    localparam int LW = ADDR_BITS + 1;
    localparam int UW = ((LW > REQ_BITS) ? LW : REQ_BITS) + 1;
    localparam logic [UW-1:0] SPAN = UW'({1'b1, {ADDR_BITS{1'b0}}});

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FREE_CHK = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_EV  = 4'd3;
    localparam logic [3:0] S_ALLOC_WR = 4'd4;
    localparam logic [3:0] S_FREE_RES = 4'd5;
    localparam logic [3:0] S_MERGE    = 4'd6;
    localparam logic [3:0] S_MV_CHK   = 4'd7;
    localparam logic [3:0] S_MV_RD    = 4'd8;
    localparam logic [3:0] S_MV_WR    = 4'd9;
    localparam logic [3:0] S_INS_WR   = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    logic [3:0]       state_reg, state_next;
    logic [1:0]       mode_reg;
    logic [UW-1:0]    req_reg;
    logic [AW-1:0]    a_reg;
    logic [UW-1:0]    end_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    idx_reg;
    logic [CW-1:0]    p_reg;
    logic [CW-1:0]    dst_reg;
    logic             drop_reg;
    logic [AW-1:0]    prev_start_reg;
    logic [LW-1:0]    prev_len_reg;
    logic [UW-1:0]    prev_end_reg;
    logic             succ_found_reg;
    logic [AW-1:0]    succ_start_reg;
    logic [LW-1:0]    succ_len_reg;
    logic [LW-1:0]    diff_reg;
    logic [UW-1:0]    acc_reg;
    logic [1:0]       status_reg;
    logic [AW-1:0]    granted_reg;

    logic [UW-1:0]    unit_a, unit_b, unit_y;
    logic             unit_sub;
    logic             accept;
    logic             pred, succ, overlap, fits, last_entry;
    logic [CW-1:0]    idx_inc, p_dec, src_idx;

    ffca_addsub #(.WIDTH(UW)) u_unit (
        .a   (unit_a),
        .b   (unit_b),
        .sub (unit_sub),
        .y   (unit_y)
    );

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE) && res_ready;
    assign result     = '{status: status_reg, granted_address: OUT_ADDR_BITS'(granted_reg)};
    assign mem_init   = accept && (mode == MODE_CLEAR);

    assign idx_inc    = idx_reg + 1'b1;
    assign p_dec      = p_reg - 1'b1;
    assign src_idx    = drop_reg ? dst_reg + 1'b1 : dst_reg - 1'b1;
    assign last_entry = (idx_inc == count_reg);
    assign pred       = (p_reg != '0) && (prev_end_reg == UW'(a_reg));
    assign succ       = succ_found_reg && (UW'(succ_start_reg) == end_reg);
    assign overlap    = (UW'(a_reg) < unit_y) && (UW'(mem_rstart) < end_reg);
    assign fits       = !unit_y[UW-1];

    // Select operands of the shared unit for each step
    always_comb
    begin
        unit_a   = '0;
        unit_b   = '0;
        unit_sub = 1'b0;
        case (state_reg)
            S_FREE_CHK:
            begin
                unit_a = UW'(a_reg);
                unit_b = req_reg;
            end
            S_SCAN_EV:
            begin
                if (mode_reg == MODE_ALLOC)
                begin
                    unit_a   = UW'(mem_rlen);
                    unit_b   = req_reg;
                    unit_sub = 1'b1;
                end
                else
                begin
                    unit_a = UW'(mem_rstart);
                    unit_b = UW'(mem_rlen);
                end
            end
            S_ALLOC_WR:
            begin
                unit_a = UW'(granted_reg);
                unit_b = req_reg;
            end
            S_FREE_RES:
            begin
                unit_a = pred ? UW'(prev_len_reg) : UW'(succ_len_reg);
                unit_b = req_reg;
            end
            S_MERGE:
            begin
                unit_a = acc_reg;
                unit_b = UW'(succ_len_reg);
            end
            default:
            begin
                unit_a = '0;
            end
        endcase
    end

    // Drive the table read and write ports
    always_comb
    begin
        mem_re     = 1'b0;
        mem_raddr  = idx_reg[IW-1:0];
        mem_we     = 1'b0;
        mem_waddr  = idx_reg[IW-1:0];
        mem_wstart = a_reg;
        mem_wlen   = LW'(unit_y);
        case (state_reg)
            S_SCAN_RD:
            begin
                mem_re = 1'b1;
            end
            S_ALLOC_WR:
            begin
                mem_we     = 1'b1;
                mem_wstart = AW'(unit_y);
                mem_wlen   = diff_reg;
            end
            S_FREE_RES:
            begin
                if (pred && !succ)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = p_dec[IW-1:0];
                    mem_wstart = prev_start_reg;
                end
                else if (succ && !pred)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = p_reg[IW-1:0];
                end
            end
            S_MERGE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = p_dec[IW-1:0];
                mem_wstart = prev_start_reg;
            end
            S_MV_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = src_idx[IW-1:0];
            end
            S_MV_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = dst_reg[IW-1:0];
                mem_wstart = mem_rstart;
                mem_wlen   = mem_rlen;
            end
            S_INS_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = p_reg[IW-1:0];
                mem_wlen  = LW'(req_reg);
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_ALLOC)
                        state_next = (count_reg == '0) ? S_DONE : S_SCAN_RD;
                    else if (mode == MODE_FREE)
                        state_next = S_FREE_CHK;
                    else
                        state_next = S_DONE;
                end
            end
            S_FREE_CHK:
            begin
                if (req_reg == '0 || unit_y > SPAN)
                    state_next = S_DONE;
                else if (count_reg == '0)
                    state_next = S_FREE_RES;
                else
                    state_next = S_SCAN_RD;
            end
            S_SCAN_RD:
                state_next = S_SCAN_EV;
            S_SCAN_EV:
            begin
                if (mode_reg == MODE_ALLOC)
                begin
                    if (fits)
                        state_next = (LW'(unit_y) == '0) ? S_MV_CHK : S_ALLOC_WR;
                    else
                        state_next = last_entry ? S_DONE : S_SCAN_RD;
                end
                else
                begin
                    if (overlap)
                        state_next = S_DONE;
                    else
                        state_next = last_entry ? S_FREE_RES : S_SCAN_RD;
                end
            end
            S_ALLOC_WR:
                state_next = S_DONE;
            S_FREE_RES:
            begin
                if (pred && succ)
                    state_next = S_MERGE;
                else if (pred || succ)
                    state_next = S_DONE;
                else if (count_reg == CW'(FREE_SLOTS))
                    state_next = S_DONE;
                else
                    state_next = S_MV_CHK;
            end
            S_MERGE:
                state_next = S_MV_CHK;
            S_MV_CHK:
            begin
                if (drop_reg)
                    state_next = (src_idx < count_reg) ? S_MV_RD : S_DONE;
                else
                    state_next = (dst_reg > p_reg) ? S_MV_RD : S_INS_WR;
            end
            S_MV_RD:
                state_next = S_MV_WR;
            S_MV_WR:
                state_next = S_MV_CHK;
            S_INS_WR:
                state_next = S_DONE;
            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= CW'(1);
            mode_reg       <= MODE_ALLOC;
            req_reg        <= '0;
            a_reg          <= '0;
            end_reg        <= '0;
            idx_reg        <= '0;
            p_reg          <= '0;
            dst_reg        <= '0;
            drop_reg       <= 1'b0;
            prev_start_reg <= '0;
            prev_len_reg   <= '0;
            prev_end_reg   <= '0;
            succ_found_reg <= 1'b0;
            succ_start_reg <= '0;
            succ_len_reg   <= '0;
            diff_reg       <= '0;
            acc_reg        <= '0;
            status_reg     <= STATUS_OK;
            granted_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg       <= mode;
                        req_reg        <= UW'(request_size);
                        a_reg          <= AW'(block_address);
                        idx_reg        <= '0;
                        p_reg          <= '0;
                        succ_found_reg <= 1'b0;
                        granted_reg    <= '0;
                        status_reg     <= (mode == MODE_ALLOC && count_reg == '0) ?
                                          STATUS_NO_FIT : STATUS_OK;
                        if (mode == MODE_CLEAR)
                            count_reg <= CW'(1);
                    end
                end
                S_FREE_CHK:
                    end_reg <= unit_y;
                S_SCAN_EV:
                begin
                    if (mode_reg == MODE_ALLOC)
                    begin
                        if (fits)
                        begin
                            granted_reg <= mem_rstart;
                            diff_reg    <= LW'(unit_y);
                            drop_reg    <= 1'b1;
                            dst_reg     <= idx_reg;
                        end
                        else
                        begin
                            idx_reg <= idx_inc;
                            if (last_entry)
                                status_reg <= STATUS_NO_FIT;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_inc;
                        if (UW'(mem_rstart) < UW'(a_reg))
                        begin
                            p_reg          <= idx_inc;
                            prev_start_reg <= mem_rstart;
                            prev_len_reg   <= mem_rlen;
                            prev_end_reg   <= unit_y;
                        end
                        else if (!succ_found_reg)
                        begin
                            succ_found_reg <= 1'b1;
                            succ_start_reg <= mem_rstart;
                            succ_len_reg   <= mem_rlen;
                        end
                    end
                end
                S_FREE_RES:
                begin
                    acc_reg  <= unit_y;
                    drop_reg <= 1'b0;
                    dst_reg  <= count_reg;
                    if (!pred && !succ && count_reg == CW'(FREE_SLOTS))
                        status_reg <= STATUS_FULL;
                end
                S_MERGE:
                begin
                    drop_reg <= 1'b1;
                    dst_reg  <= p_reg;
                end
                S_MV_CHK:
                begin
                    if (drop_reg && !(src_idx < count_reg))
                        count_reg <= count_reg - 1'b1;
                end
                S_MV_WR:
                    dst_reg <= src_idx;
                S_INS_WR:
                    count_reg <= count_reg + 1'b1;
                default:
                begin
                    drop_reg <= drop_reg;
                end
            endcase
        end
    end

    // The table has one port of each kind, never used together
    assert property (@(posedge clk) disable iff (!rst_n) !(mem_re && mem_we))
        else $error("table read and write in the same cycle");

    // The segment count never exceeds the table depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(FREE_SLOTS))
        else $error("segment count beyond table depth");

    // An accepted transfer blocks the input until its result is out
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> !in_ready)
        else $error("input ready right after a transfer");

    // A result is only offered when the output stage can take it
    assert property (@(posedge clk) disable iff (!rst_n) res_valid |=> in_ready)
        else $error("sequencer did not return to idle after a result");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the first-fit coalescing allocator.
`timescale 1ns / 1ps

module tb_top;
    import ffca_pkg::*;

    localparam int SLOTS  = 16;
    localparam int ADDR_W = 24;
    localparam longint ADDR_SPAN = 64'd1 << ADDR_W;
    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
    localparam logic [PADDR_BITS-1:0] POOL_SIZE_ADDR = {REG_POOL_SIZE, 2'b00};
    localparam int PHASE_OPS = 130;

    typedef bit [ADDR_W-1:0] base_t;
    typedef bit [ADDR_W:0]   len_t;

    typedef struct packed {
        logic [MODE_BITS-1:0]     mode;
        logic [REQ_BITS-1:0]      size;
        logic [OUT_ADDR_BITS-1:0] addr;
    } alloc_op_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [MODE_BITS-1:0]     mode = '0;
    logic [REQ_BITS-1:0]      request_size = '0;
    logic [OUT_ADDR_BITS-1:0] block_address = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [STATUS_BITS-1:0]   status;
    logic [OUT_ADDR_BITS-1:0] granted_address;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [PADDR_BITS-1:0]    paddr = '0;
    logic [PDATA_BITS-1:0]    pwdata = '0;
    logic [PDATA_BITS-1:0]    prdata;
    logic                     pready;

    // Free-segment table as the allocator should hold it
    base_t              seg_base [SLOTS];
    len_t               seg_size [SLOTS];
    int                 seg_count;
    bit [POOL_BITS-1:0] pool_shadow = POOL_RESET;

    // Blocks handed out and not yet returned, used to build legal frees
    longint live_base [$];
    longint live_len [$];

    alloc_op_t pending_ops [$];
    result_t   expected_results [$];

    logic in_taken = 1'b0;
    int   gap_left = 0;
    int   burst_left = 0;
    int   stall_left = 0;
    int   stall_style = 0;
    int   error_count = 0;

    bit [31:0] pool_plan [9] = '{32'd1, 32'd0, 32'd300, 32'hFE00_0040, 32'd1000,
                                 32'h01FF_FFFF, 32'd4096, 32'd16777216, 32'd120};

    first_fit_coalescing_allocator #(
        .FREE_SLOTS (SLOTS),
        .ADDR_BITS  (ADDR_W)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .request_size    (request_size),
        .block_address   (block_address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .granted_address (granted_address),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Clamp the register value to a usable pool size
    function automatic longint pool_bytes();
        longint p = pool_shadow;
        if (p == 0)
            p = 1;
        if (p > ADDR_SPAN)
            p = ADDR_SPAN;
        return p;
    endfunction

    function automatic void rebuild_pool();
        for (int i = 0; i < SLOTS; i++)
        begin
            seg_base[i] = '0;
            seg_size[i] = '0;
        end
        seg_size[0] = len_t'(pool_bytes());
        seg_count = 1;
    endfunction

    function automatic void drop_segment(int k);
        for (int i = k; i + 1 < seg_count; i++)
        begin
            seg_base[i] = seg_base[i + 1];
            seg_size[i] = seg_size[i + 1];
        end
        if (seg_count > 0)
            seg_count--;
    endfunction

    // Take the block from the low end of the first segment that fits
    function automatic logic [STATUS_BITS-1:0] carve_block(longint req, output base_t where);
        where = '0;
        for (int i = 0; i < seg_count; i++)
        begin
            if (longint'(seg_size[i]) >= req)
            begin
                where = seg_base[i];
                seg_size[i] = len_t'(longint'(seg_size[i]) - req);
                if (seg_size[i] == 0)
                    drop_segment(i);
                else
                    seg_base[i] = base_t'(longint'(seg_base[i]) + req);
                return STATUS_OK;
            end
        end
        return STATUS_NO_FIT;
    endfunction

    // Insert a returned block in address order and merge with its neighbors
    function automatic logic [STATUS_BITS-1:0] release_block(longint a, longint s);
        longint stop = a + s;
        int     p = 0;
        bit     joins_prev;
        bit     joins_next;
        if (s == 0 || stop > ADDR_SPAN)
            return STATUS_OK;
        for (int i = 0; i < seg_count; i++)
        begin
            if (a < longint'(seg_base[i]) + longint'(seg_size[i]) &&
                longint'(seg_base[i]) < stop)
                return STATUS_OK;
        end
        while (p < seg_count && longint'(seg_base[p]) < a)
            p++;
        joins_prev = p > 0 && longint'(seg_base[p - 1]) + longint'(seg_size[p - 1]) == a;
        joins_next = p < seg_count && longint'(seg_base[p]) == stop;
        if (joins_prev && joins_next)
        begin
            seg_size[p - 1] = len_t'(longint'(seg_size[p - 1]) + s + longint'(seg_size[p]));
            drop_segment(p);
        end
        else if (joins_prev)
        begin
            seg_size[p - 1] = len_t'(longint'(seg_size[p - 1]) + s);
        end
        else if (joins_next)
        begin
            seg_base[p] = base_t'(a);
            seg_size[p] = len_t'(longint'(seg_size[p]) + s);
        end
        else
        begin
            if (seg_count >= SLOTS)
                return STATUS_FULL;
            for (int i = seg_count; i > p; i--)
            begin
                seg_base[i] = seg_base[i - 1];
                seg_size[i] = seg_size[i - 1];
            end
            seg_base[p] = base_t'(a);
            seg_size[p] = len_t'(s);
            seg_count++;
        end
        return STATUS_OK;
    endfunction

    function automatic result_t predict_result(alloc_op_t op);
        result_t r;
        base_t   where;
        r.status = STATUS_OK;
        r.granted_address = '0;
        case (op.mode)
            MODE_ALLOC:
            begin
                r.status = carve_block(longint'(op.size), where);
                if (r.status == STATUS_OK)
                    r.granted_address = where;
            end
            MODE_FREE:  r.status = release_block(longint'(op.addr), longint'(op.size));
            MODE_CLEAR: rebuild_pool();
            default:    ;
        endcase
        return r;
    endfunction

    // Predict an operation, then queue it and its result
    task automatic queue_op(logic [MODE_BITS-1:0] m, longint sz, longint ad);
        alloc_op_t op;
        result_t   r;
        op.mode = m;
        op.size = sz[REQ_BITS-1:0];
        op.addr = ad[OUT_ADDR_BITS-1:0];
        r = predict_result(op);
        pending_ops.push_back(op);
        expected_results.push_back(r);
        if (m == MODE_ALLOC && r.status == STATUS_OK && op.size != 0)
        begin
            live_base.push_back(longint'(r.granted_address));
            live_len.push_back(longint'(op.size));
        end
        if (m == MODE_CLEAR)
        begin
            live_base.delete();
            live_len.delete();
        end
    endtask

    // Mostly allocations and frees of live blocks; some junk frees, clears, unused mode
    task automatic queue_random_op();
        int     pick = $urandom_range(0, 99);
        int     roll = $urandom_range(0, 99);
        int     k;
        longint a;
        longint s;
        longint cap = pool_bytes() / 6;
        if (cap < 1)
            cap = 1;
        if (pick < 40 || (pick < 82 && live_base.size() == 0))
        begin
            if (roll < 3)
                s = 0;
            else if (roll < 7)
                s = $urandom_range(0, 32'h01FF_FFFF);
            else if (roll < 17 && seg_count > 0)
                s = seg_size[$urandom_range(0, seg_count - 1)];
            else
                s = $urandom_range(1, cap);
            queue_op(MODE_ALLOC, s, $urandom());
        end
        else if (pick < 82)
        begin
            k = $urandom_range(0, live_base.size() - 1);
            a = live_base[k];
            s = live_len[k];
            if (s > 1 && roll < 25)
            begin
                // return the low part, keep the rest allocated
                s = $urandom_range(1, s - 1);
                live_base[k] = a + s;
                live_len[k] = live_len[k] - s;
            end
            else
            begin
                live_base.delete(k);
                live_len.delete(k);
            end
            queue_op(MODE_FREE, s, a);
        end
        else if (pick < 93)
        begin
            if (roll < 30)
                a = $urandom_range(0, 32'h00FF_FFFF);
            else
                a = $urandom_range(0, pool_bytes() - 1);
            if ($urandom_range(0, 3) == 0)
                s = $urandom_range(0, 32'h01FF_FFFF);
            else
                s = $urandom_range(0, cap);
            queue_op(MODE_FREE, s, a);
        end
        else if (pick < 97)
        begin
            queue_op(MODE_CLEAR, $urandom(), $urandom());
        end
        else
        begin
            queue_op(MODE_UNUSED, $urandom(), $urandom());
        end
    endtask

    task automatic log_mismatch(string what, longint want_v, longint got_v);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s expected %0h got %0h", $time, what, want_v, got_v);
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Register write: setup cycle, then access cycle
    task automatic write_pool_size(logic [PDATA_BITS-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= POOL_SIZE_ADDR;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        pool_shadow = value[POOL_BITS-1:0];
    endtask

    // Drive request transfers in bursts separated by random gaps
    always @(negedge clk)
    begin
        alloc_op_t op;
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_ops.size() != 0)
            begin
                op = pending_ops.pop_front();
                in_valid <= 1'b1;
                mode <= op.mode;
                request_size <= op.size;
                block_address <= op.addr;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall the result side, switching to a new random style when each stretch runs out
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 300);
        end
        else
        begin
            stall_left--;
        end
        case (stall_style)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 1) == 1);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Check each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                log_mismatch("result with nothing pending", 0,
                             longint'({status, granted_address}));
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    log_mismatch("status", longint'(want.status), longint'(status));
                if (granted_address !== want.granted_address)
                    log_mismatch("granted_address", longint'(want.granted_address),
                                 longint'(granted_address));
            end
        end
    end

    initial
    begin
        rebuild_pool();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Whole default pool in one request
        @(posedge clk);
        queue_op(MODE_ALLOC, 64'd16777216, 0);
        wait_drained();

        // Small pool: zero-byte, oversized, empty table, then fill the table
        write_pool_size(32'd32);
        @(posedge clk);
        queue_op(MODE_CLEAR, 0, 0);
        queue_op(MODE_ALLOC, 0, 0);
        queue_op(MODE_ALLOC, 33, 0);
        queue_op(MODE_ALLOC, 32'h01FF_FFFF, 0);
        queue_op(MODE_ALLOC, 32, 0);
        queue_op(MODE_ALLOC, 0, 0);
        queue_op(MODE_FREE, 0, 5);
        for (int i = 0; i < SLOTS; i++)
            queue_op(MODE_FREE, 1, 2 * i);
        queue_op(MODE_FREE, 1, 40);
        queue_op(MODE_FREE, 1, 1);
        queue_op(MODE_FREE, 2, 24'hFF_FFFF);
        queue_op(MODE_FREE, 1, 4);
        queue_op(MODE_UNUSED, 32'h01FF_FFFF, 24'hFF_FFFF);
        queue_op(MODE_ALLOC, 3, 0);
        queue_op(MODE_FREE, 1, 3);

        // Random phases, one pool setting each; hold off until drained
        for (int ph = 0; ph < 9; ph++)
        begin
            wait_drained();
            write_pool_size(pool_plan[ph]);
            @(posedge clk);
            if ($urandom_range(0, 3) != 0)
                queue_op(MODE_CLEAR, $urandom(), $urandom());
            for (int n = 0; n < PHASE_OPS; n++)
                queue_random_op();
        end

        wait_drained();
        repeat (100) @(negedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("first_fit_coalescing_allocator: match");
        else
            $display("first_fit_coalescing_allocator: mismatch");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("first_fit_coalescing_allocator: mismatch");
        $finish;
    end

endmodule
